[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[src/asoc_pkg.sv]
// ----------------------------------------------------------------------------
// asoc_pkg
// Types, constants and arithmetic helpers of the ARGB source-over compositor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asoc_pkg;

   localparam int FB_DIM_BITS    = 13;
   localparam int CSR_INDEX_BITS = 8;

   typedef enum logic [1:0] {
      OP_FILL  = 2'd0,
      OP_COPY  = 2'd1,
      OP_BLEND = 2'd2
   } op_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILL_COLOR   = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GLOBAL_ALPHA = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FB_WIDTH     = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FB_HEIGHT    = 8'd3;

   localparam logic [31:0]            FILL_COLOR_RESET   = 32'h0000_0000;
   localparam logic [7:0]             GLOBAL_ALPHA_RESET = 8'hFF;
   localparam logic [FB_DIM_BITS-1:0] FB_WIDTH_RESET     = 13'd320;
   localparam logic [FB_DIM_BITS-1:0] FB_HEIGHT_RESET    = 13'd240;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] ROUND_HALF   = 8'h80;

   // pixel viewed as four channels: [3] alpha, [2] red, [1] green, [0] blue
   typedef logic [3:0][7:0] pixel_type;

   typedef struct packed {
      logic [31:0]            fill_color;
      logic [7:0]             global_alpha;
      logic [FB_DIM_BITS-1:0] fb_width;
      logic [FB_DIM_BITS-1:0] fb_height;
   } cfg_type;

   // rounded x / 255, exact for x up to 255 * 255
   function automatic logic [7:0] rdiv255(input logic [15:0] v);
      logic [16:0] t;
      logic [16:0] u;
      t = 17'(v) + 17'(ROUND_HALF);
      u = t + (t >> 8);
      return u[15:8];
   endfunction

endpackage

[src/asoc_if.sv]
// ----------------------------------------------------------------------------
// asoc channel interfaces
// Request, response and register-write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface asoc_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   operation;
   logic signed [COORD_BITS-1:0] dest_x;
   logic signed [COORD_BITS-1:0] dest_y;
   logic [31:0]                  dest_pixel;
   logic [31:0]                  source_pixel;
   logic                         end_of_rect;

   modport source (output valid, operation, dest_x, dest_y, dest_pixel, source_pixel,
                   end_of_rect, input ready);
   modport sink (input valid, operation, dest_x, dest_y, dest_pixel, source_pixel,
                 end_of_rect, output ready);
endinterface

interface asoc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_pixel;
   logic        write_strobe;
   logic        end_of_rect_out;

   modport source (output valid, result_pixel, write_strobe, end_of_rect_out, input ready);
   modport sink (input valid, result_pixel, write_strobe, end_of_rect_out, output ready);
endinterface

interface asoc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/asoc_pipe.sv]
// ----------------------------------------------------------------------------
// asoc_pipe
// Five-stage compositing pipeline: clip and select, scale multiply, rounded
// divide, destination multiply, add/saturate into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module asoc_pipe
   import asoc_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   asoc_req_if.sink       req_chan,
   asoc_rsp_if.source     rsp_chan
);

   localparam int CMP_W = (COORD_BITS > FB_DIM_BITS) ? COORD_BITS : FB_DIM_BITS;

   typedef struct packed {
      logic        ok;
      pixel_type   chan;
      logic [7:0]  fac_a;
      logic [7:0]  fac_c;
      pixel_type   dst;
      logic        eor;
   } s1_type;

   typedef struct packed {
      logic             ok;
      logic [3:0][15:0] prod;
      pixel_type        dst;
      logic             eor;
   } s2_type;

   typedef struct packed {
      logic            wr;
      logic [2:0][7:0] src;
      logic [7:0]      inv;
      pixel_type       dst;
      logic            eor;
   } s3_type;

   typedef struct packed {
      logic             wr;
      logic [2:0][7:0]  src;
      logic [2:0][15:0] dprod;
      pixel_type        dst;
      logic             eor;
   } s4_type;

   typedef struct packed {
      logic [31:0] result;
      logic        wr;
      logic        eor;
   } s5_type;

   logic   v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic   en1, en2, en3, en4, en5;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;

   // each stage moves when it is empty or its successor moves
   assign en5 = !v5_ff || rsp_chan.ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   // stage 1: clipping and choice of channels and scale factors
   always_comb begin
      logic      in_bounds;
      pixel_type fill;
      fill      = pixel_type'(cfg.fill_color);
      in_bounds = !req_chan.dest_x[COORD_BITS-1] && !req_chan.dest_y[COORD_BITS-1]
                  && (CMP_W'($unsigned(req_chan.dest_x)) < CMP_W'(cfg.fb_width))
                  && (CMP_W'($unsigned(req_chan.dest_y)) < CMP_W'(cfg.fb_height));
      s1_in.dst   = pixel_type'(req_chan.dest_pixel);
      s1_in.eor   = req_chan.end_of_rect;
      s1_in.chan  = pixel_type'(req_chan.source_pixel);
      s1_in.fac_a = ALPHA_OPAQUE;
      s1_in.fac_c = ALPHA_OPAQUE;
      s1_in.ok    = in_bounds;
      case (op_type'(req_chan.operation))
         OP_FILL: begin
            // straight alpha: premultiply colour by its own alpha
            s1_in.chan  = fill;
            s1_in.fac_c = fill[3];
         end
         OP_COPY: begin
         end
         OP_BLEND: begin
            s1_in.fac_a = cfg.global_alpha;
            s1_in.fac_c = cfg.global_alpha;
         end
         default: begin
            s1_in.ok = 1'b0;
         end
      endcase
   end

   // stage 2: source scaling products
   always_comb begin
      s2_in.ok      = s1_ff.ok;
      s2_in.dst     = s1_ff.dst;
      s2_in.eor     = s1_ff.eor;
      s2_in.prod[3] = 16'(s1_ff.chan[3]) * 16'(s1_ff.fac_a);
      for (int i = 0; i < 3; i++) begin
         s2_in.prod[i] = 16'(s1_ff.chan[i]) * 16'(s1_ff.fac_c);
      end
   end

   // stage 3: rounded divide; a zero scaled alpha means nothing to write
   always_comb begin
      logic [7:0] sa;
      sa        = rdiv255(s2_ff.prod[3]);
      s3_in.wr  = s2_ff.ok && (sa != 8'd0);
      s3_in.inv = ~sa;
      s3_in.dst = s2_ff.dst;
      s3_in.eor = s2_ff.eor;
      for (int i = 0; i < 3; i++) begin
         s3_in.src[i] = rdiv255(s2_ff.prod[i]);
      end
   end

   // stage 4: destination weighted by inverse source alpha
   always_comb begin
      s4_in.wr  = s3_ff.wr;
      s4_in.src = s3_ff.src;
      s4_in.dst = s3_ff.dst;
      s4_in.eor = s3_ff.eor;
      for (int i = 0; i < 3; i++) begin
         s4_in.dprod[i] = 16'(s3_ff.dst[i]) * 16'(s3_ff.inv);
      end
   end

   // stage 5: add, saturate against malformed premultiplied input
   always_comb begin
      logic [8:0] sum;
      pixel_type  res;
      res[3] = ALPHA_OPAQUE;
      for (int i = 0; i < 3; i++) begin
         sum    = 9'(s4_ff.src[i]) + 9'(rdiv255(s4_ff.dprod[i]));
         res[i] = sum[8] ? 8'hFF : sum[7:0];
      end
      s5_in.wr     = s4_ff.wr;
      s5_in.eor    = s4_ff.eor;
      s5_in.result = s4_ff.wr ? 32'(res) : 32'(s4_ff.dst);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
      if (en4) s4_ff <= s4_in;
      if (en5) s5_ff <= s5_in;
   end

   assign rsp_chan.valid           = v5_ff;
   assign rsp_chan.result_pixel    = s5_ff.result;
   assign rsp_chan.write_strobe    = s5_ff.wr;
   assign rsp_chan.end_of_rect_out = s5_ff.eor;

   `ASSERT_HOLDS(a_wr_opaque, clock, reset, !v5_ff || !s5_ff.wr || (s5_ff.result[31:24] == ALPHA_OPAQUE), "written pixel not opaque")
   `ASSERT_HOLDS(a_full_stall, clock, reset, !(v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && !rsp_chan.ready) || !req_chan.ready, "ready while pipeline full and stalled")
   `ASSERT_NEXT(a_take_lands, clock, reset, req_chan.valid && req_chan.ready, v1_ff, "accepted pixel lost at stage 1")
   `ASSERT_NEXT(a_hold_mid, clock, reset, v4_ff && !en4, v4_ff && $stable(s4_ff), "stalled stage 4 item changed")

endmodule

[src/argb_source_over_compositor.sv]
// ----------------------------------------------------------------------------
// argb_source_over_compositor
// Per-pixel source-over compositor onto an opaque ARGB8888 framebuffer.
// ----------------------------------------------------------------------------
// One pixel is taken per clock. The stages are clip and select, source
// scaling multiply, rounded divide by 255, destination weighting multiply,
// and a second rounded divide joined with add/saturate into the output
// register. Every stage holds its item when the one after it is stalled, so
// bubbles are squeezed out and throughput stays at one pixel per clock while
// the result side keeps up. Register writes take effect at once and are
// meant to be made with no pixels in flight.
`timescale 1ns / 1ps

module argb_source_over_compositor
   import asoc_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   asoc_req_if.sink   req_chan,
   asoc_rsp_if.source rsp_chan,
   asoc_csr_if.sink   csr_chan
);

   cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_FILL_COLOR:   cfg_in.fill_color   = csr_chan.data;
            CSR_GLOBAL_ALPHA: cfg_in.global_alpha = csr_chan.data[7:0];
            CSR_FB_WIDTH:     cfg_in.fb_width     = csr_chan.data[FB_DIM_BITS-1:0];
            CSR_FB_HEIGHT:    cfg_in.fb_height    = csr_chan.data[FB_DIM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fill_color   <= FILL_COLOR_RESET;
         cfg_ff.global_alpha <= GLOBAL_ALPHA_RESET;
         cfg_ff.fb_width     <= FB_WIDTH_RESET;
         cfg_ff.fb_height    <= FB_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   asoc_pipe #(
      .COORD_BITS (COORD_BITS)
   ) u_pipe (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

[tb/sv/argb_source_over_compositor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb_source_over_compositor_tb
// Self-checking bench for the source-over compositor. A directed table walks
// clipping edges, alpha extremes, every operation and register extremes. It
// is followed by randomised phases, each under fresh register settings. Both
// the pixel sender and the result receiver idle at random. Every result
// transfer is checked in order against the table's expected value or a
// local model of the compositing arithmetic.
// ----------------------------------------------------------------------------

module argb_source_over_compositor_tb;
   import asoc_pkg::*;

   localparam int          COORD_BITS   = 16;
   localparam int          RANDOM_ITEMS = 1850;
   localparam int          PHASES       = 12;
   localparam int          TAIL_CYCLES  = 20;
   localparam int          CYCLE_LIMIT  = 300000;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;

   typedef struct packed {
      logic [1:0]            operation;
      logic [COORD_BITS-1:0] dest_x;
      logic [COORD_BITS-1:0] dest_y;
      logic [31:0]           dest_pixel;
      logic [31:0]           source_pixel;
      logic                  end_of_rect;
   } pixel_job_t;

   typedef struct packed {
      logic [31:0] pixel;
      logic        strobe;
      logic        eor;
   } pixel_result_t;

   typedef struct packed {
      logic [2:0]    setting;
      pixel_job_t    job;
      logic          typed;
      pixel_result_t want;
   } directed_row_t;

   logic clock;
   logic reset;

   asoc_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   asoc_rsp_if                            rsp_chan ();
   asoc_csr_if                            csr_chan ();

   argb_source_over_compositor #(.COORD_BITS(COORD_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   cfg_type         active_cfg;
   cfg_type         directed_settings [5];
   directed_row_t   directed_rows [$];
   pixel_result_t   pending_pixels [$];
   int              fail_count;
   int              cycle_count;
   bit              no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("argb_source_over_compositor regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic logic [7:0] div255_rounded(input int unsigned v);
      int unsigned t;
      t = v + 32'd128;
      return 8'((t + (t >> 8)) >> 8);
   endfunction

   function automatic logic [7:0] over_channel(input logic [7:0] s, input logic [7:0] d,
                                               input logic [7:0] sa);
      int unsigned sum;
      sum = int'(s) + int'(div255_rounded(int'(d) * (32'd255 - int'(sa))));
      return (sum > 255) ? 8'hFF : sum[7:0];
   endfunction

   function automatic logic [31:0] blend_over(input logic [31:0] dst, input logic [7:0] sa,
                                              input logic [7:0] sr, input logic [7:0] sg,
                                              input logic [7:0] sb);
      return {8'hFF, over_channel(sr, dst[23:16], sa), over_channel(sg, dst[15:8], sa),
              over_channel(sb, dst[7:0], sa)};
   endfunction

   function automatic pixel_result_t composite_pixel(input pixel_job_t j);
      pixel_result_t r;
      int            xi;
      int            yi;
      logic [7:0]    a;
      logic [7:0]    ga;
      logic [31:0]   fc;
      logic [31:0]   sp;
      xi = int'($signed(j.dest_x));
      yi = int'($signed(j.dest_y));
      fc = active_cfg.fill_color;
      ga = active_cfg.global_alpha;
      sp = j.source_pixel;
      r.pixel  = j.dest_pixel;
      r.strobe = 1'b0;
      r.eor    = j.end_of_rect;
      if (xi >= 0 && yi >= 0 && xi < int'(active_cfg.fb_width)
          && yi < int'(active_cfg.fb_height)) begin
         case (j.operation)
            OP_FILL: begin
               a = fc[31:24];
               if (a == 8'hFF) begin
                  r.pixel  = {8'hFF, fc[23:0]};
                  r.strobe = 1'b1;
               end else if (a != 8'h00) begin
                  r.pixel  = blend_over(j.dest_pixel, a,
                                        div255_rounded(int'(fc[23:16]) * int'(a)),
                                        div255_rounded(int'(fc[15:8]) * int'(a)),
                                        div255_rounded(int'(fc[7:0]) * int'(a)));
                  r.strobe = 1'b1;
               end
            end
            OP_COPY: begin
               a = sp[31:24];
               if (a == 8'hFF) begin
                  r.pixel  = sp;
                  r.strobe = 1'b1;
               end else if (a != 8'h00) begin
                  r.pixel  = blend_over(j.dest_pixel, a, sp[23:16], sp[15:8], sp[7:0]);
                  r.strobe = 1'b1;
               end
            end
            OP_BLEND: begin
               if (ga != 8'h00) begin
                  a = div255_rounded(int'(sp[31:24]) * int'(ga));
                  if (a != 8'h00) begin
                     r.pixel  = blend_over(j.dest_pixel, a,
                                           div255_rounded(int'(sp[23:16]) * int'(ga)),
                                           div255_rounded(int'(sp[15:8]) * int'(ga)),
                                           div255_rounded(int'(sp[7:0]) * int'(ga)));
                     r.strobe = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   // ------------------------------------------------------------ stimulus

   function automatic int draw_gap();
      return no_idle ? 0 : int'($urandom_range(0, 7));
   endfunction

   task automatic send_job(input pixel_job_t j, input logic typed, input pixel_result_t want);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= j.operation;
      req_chan.dest_x       <= j.dest_x;
      req_chan.dest_y       <= j.dest_y;
      req_chan.dest_pixel   <= j.dest_pixel;
      req_chan.source_pixel <= j.source_pixel;
      req_chan.end_of_rect  <= j.end_of_rect;
      do @(posedge clock); while (!req_chan.ready);
      pending_pixels.push_back(typed ? want : composite_pixel(j));
   endtask

   // sender holds off until every pixel in flight has come back
   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   task automatic load_settings(input cfg_type s);
      logic [7:0]  idx;
      logic [31:0] word;
      for (int i = 0; i < 4; i++) begin
         case (i)
            0: begin
               idx  = CSR_FILL_COLOR;
               word = s.fill_color;
            end
            1: begin
               idx  = CSR_GLOBAL_ALPHA;
               word = ($urandom() & 32'hFFFF_FF00) | 32'(s.global_alpha);
            end
            2: begin
               idx  = CSR_FB_WIDTH;
               word = ($urandom() & 32'hFFFF_E000) | 32'(s.fb_width);
            end
            default: begin
               idx  = CSR_FB_HEIGHT;
               word = ($urandom() & 32'hFFFF_E000) | 32'(s.fb_height);
            end
         endcase
         csr_chan.valid <= 1'b1;
         csr_chan.index <= idx;
         csr_chan.data  <= word;
         do @(posedge clock); while (!csr_chan.ready);
         case (idx)
            CSR_FILL_COLOR:   active_cfg.fill_color   = word;
            CSR_GLOBAL_ALPHA: active_cfg.global_alpha = word[7:0];
            CSR_FB_WIDTH:     active_cfg.fb_width     = word[FB_DIM_BITS-1:0];
            CSR_FB_HEIGHT:    active_cfg.fb_height    = word[FB_DIM_BITS-1:0];
            default: ;
         endcase
      end
      csr_chan.valid <= 1'b0;
   endtask

   task automatic add_row(input logic [2:0] setting, input logic [1:0] op, input int x,
                          input int y, input logic [31:0] dest, input logic [31:0] src,
                          input logic eor, input logic typed, input logic [31:0] want_pixel,
                          input logic want_strobe);
      directed_row_t row;
      row.setting           = setting;
      row.job.operation     = op;
      row.job.dest_x        = COORD_BITS'(x);
      row.job.dest_y        = COORD_BITS'(y);
      row.job.dest_pixel    = dest;
      row.job.source_pixel  = src;
      row.job.end_of_rect   = eor;
      row.typed             = typed;
      row.want.pixel        = want_pixel;
      row.want.strobe       = want_strobe;
      row.want.eor          = eor;
      directed_rows.push_back(row);
   endtask

   task automatic build_directed();
      directed_settings[0] = '{FILL_COLOR_RESET, GLOBAL_ALPHA_RESET, FB_WIDTH_RESET,
                               FB_HEIGHT_RESET};
      directed_settings[1] = '{32'hFFAB_CDEF, 8'h00, 13'd4096, 13'd4096};
      directed_settings[2] = '{32'h80FF_4001, 8'h80, 13'd0, 13'd240};
      directed_settings[3] = '{32'h01FF_FFFF, 8'h01, 13'd1, 13'd1};
      directed_settings[4] = '{32'hFFFF_FFFF, 8'hFF, 13'd8191, 13'd8191};
      // settings after reset: fill colour is fully transparent
      add_row(0, OP_FILL,  5, 5, 32'h1234_5678, 32'hFFFF_FFFF, 0, 1, 32'h1234_5678, 0);
      add_row(0, OP_COPY,  0, 0, 32'h0000_0000, 32'hFF00_FF00, 1, 1, 32'hFF00_FF00, 1);
      add_row(0, OP_COPY,  319, 239, 32'hFFFF_FFFF, 32'h00FF_FFFF, 0, 1, 32'hFFFF_FFFF, 0);
      add_row(0, OP_COPY,  320, 0, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 1, 1, 32'hA5A5_A5A5, 0);
      add_row(0, OP_COPY,  0, 240, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 0, 1, 32'h5A5A_5A5A, 0);
      add_row(0, OP_COPY,  -1, 0, 32'h0F0F_0F0F, 32'hFFFF_FFFF, 0, 1, 32'h0F0F_0F0F, 0);
      add_row(0, OP_BLEND, 32767, -32768, 32'hF0F0_F0F0, 32'hFFFF_FFFF, 1, 1,
              32'hF0F0_F0F0, 0);
      add_row(0, OP_UNUSED, 1, 1, 32'h5A5A_5A5A, 32'hFF11_2233, 0, 1, 32'h5A5A_5A5A, 0);
      add_row(0, OP_BLEND, 10, 10, 32'h0000_0000, 32'hFF12_3456, 1, 1, 32'hFF12_3456, 1);
      add_row(0, OP_BLEND, 11, 10, 32'h8765_4321, 32'h0000_0000, 0, 1, 32'h8765_4321, 0);
      add_row(0, OP_COPY,  100, 100, 32'hFF80_8080, 32'h8040_2010, 0, 0, '0, 0);
      // colour channels above alpha must clamp, not carry
      add_row(0, OP_COPY,  101, 100, 32'hFFFF_FFFF, 32'h80FF_00FF, 1, 0, '0, 0);
      add_row(0, OP_BLEND, 102, 100, 32'hFF20_4060, 32'hC080_6040, 0, 0, '0, 0);
      // opaque fill, zero global alpha, 4096 square
      add_row(1, OP_FILL,  4095, 4095, 32'h0000_0000, 32'h0000_0000, 1, 1, 32'hFFAB_CDEF, 1);
      add_row(1, OP_FILL,  4096, 100, 32'h1357_9BDF, 32'h0000_0000, 0, 1, 32'h1357_9BDF, 0);
      add_row(1, OP_BLEND, 0, 0, 32'h1122_3344, 32'hFFFF_FFFF, 0, 1, 32'h1122_3344, 0);
      add_row(1, OP_COPY,  2000, 3000, 32'h0000_0000, 32'hFFC0_FFEE, 1, 1, 32'hFFC0_FFEE, 1);
      // zero width clips everything
      add_row(2, OP_FILL,  0, 0, 32'h3333_3333, 32'h0000_0000, 0, 1, 32'h3333_3333, 0);
      add_row(2, OP_COPY,  0, 0, 32'h4444_4444, 32'hFF00_0000, 1, 1, 32'h4444_4444, 0);
      // one pixel framebuffer, faintest fill and global alpha
      add_row(3, OP_FILL,  0, 0, 32'hFF00_0000, 32'h0000_0000, 0, 0, '0, 0);
      add_row(3, OP_FILL,  0, 1, 32'h7777_7777, 32'h0000_0000, 1, 1, 32'h7777_7777, 0);
      add_row(3, OP_BLEND, 0, 0, 32'h0000_0000, 32'hFFFF_FFFF, 0, 0, '0, 0);
      add_row(3, OP_BLEND, 0, 0, 32'hFFFF_FFFF, 32'h7F7F_7F7F, 1, 0, '0, 0);
      // largest register values
      add_row(4, OP_FILL,  8190, 8190, 32'h0000_0000, 32'h0000_0000, 1, 1, 32'hFFFF_FFFF, 1);
      add_row(4, OP_COPY,  8191, 0, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 0, 1, 32'hDEAD_BEEF, 0);
   endtask

   function automatic logic [FB_DIM_BITS-1:0] random_dim();
      case ($urandom_range(0, 9))
         0:       return 13'd1;
         1:       return 13'd4096;
         2:       return 13'd8191;
         3:       return 13'd0;
         4, 5:    return FB_DIM_BITS'($urandom_range(1, 4096));
         default: return FB_DIM_BITS'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      case ($urandom_range(0, 3))
         0:       s.fill_color = {8'h00, 24'($urandom())};
         1:       s.fill_color = {8'hFF, 24'($urandom())};
         default: s.fill_color = $urandom();
      endcase
      case ($urandom_range(0, 4))
         0:       s.global_alpha = 8'h00;
         1:       s.global_alpha = 8'hFF;
         default: s.global_alpha = 8'($urandom());
      endcase
      s.fb_width  = random_dim();
      s.fb_height = random_dim();
      return s;
   endfunction

   // mostly inside the framebuffer, with the edges and the far ends of the range
   function automatic logic [COORD_BITS-1:0] random_coord(input int lim);
      case ($urandom_range(0, 9))
         6:       return COORD_BITS'(lim - 1 + int'($urandom_range(0, 2)));
         7:       return COORD_BITS'(-int'($urandom_range(1, 4)));
         8:       return COORD_BITS'($urandom());
         9: begin
            case ($urandom_range(0, 2))
               0:       return 16'h7FFF;
               1:       return 16'h8000;
               default: return 16'h0000;
            endcase
         end
         default: return (lim > 0) ? COORD_BITS'($urandom_range(0, lim - 1)) : '0;
      endcase
   endfunction

   function automatic logic [31:0] random_source();
      logic [7:0] a;
      case ($urandom_range(0, 9))
         0:       a = 8'h00;
         1, 2:    a = 8'hFF;
         default: a = 8'($urandom());
      endcase
      if ($urandom_range(0, 6) == 0)
         return {a, 24'($urandom())};
      return {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)), 8'($urandom_range(0, a))};
   endfunction

   function automatic pixel_job_t random_job();
      pixel_job_t j;
      j.operation    = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
      j.dest_x       = random_coord(int'(active_cfg.fb_width));
      j.dest_y       = random_coord(int'(active_cfg.fb_height));
      j.dest_pixel   = $urandom();
      j.source_pixel = random_source();
      j.end_of_rect  = ($urandom_range(0, 7) == 0);
      return j;
   endfunction

   // ---------------------------------------------------------- result side

   initial begin : result_sink
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   always @(posedge clock) begin : result_check
      pixel_result_t got;
      pixel_result_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.pixel  = rsp_chan.result_pixel;
         got.strobe = rsp_chan.write_strobe;
         got.eor    = rsp_chan.end_of_rect_out;
         if (pending_pixels.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result transfer: pixel %h strobe %b eor %b",
                        got.pixel, got.strobe, got.eor);
         end else begin
            want = pending_pixels.pop_front();
            if (got.pixel !== want.pixel || got.strobe !== want.strobe
                || got.eor !== want.eor) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: pixel %h/%h strobe %b/%b eor %b/%b (expected/actual)",
                           want.pixel, got.pixel, want.strobe, got.strobe,
                           want.eor, got.eor);
            end
         end
      end
   end

   // ---------------------------------------------------------------- main

   initial begin : main_sequence
      logic [2:0] current_setting;
      int         per_phase;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.operation    = OP_FILL;
      req_chan.dest_x       = '0;
      req_chan.dest_y       = '0;
      req_chan.dest_pixel   = '0;
      req_chan.source_pixel = '0;
      req_chan.end_of_rect  = 1'b0;
      rsp_chan.ready        = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = CSR_FILL_COLOR;
      csr_chan.data         = '0;
      fail_count            = 0;
      cycle_count           = 0;
      no_idle               = 1'b0;
      active_cfg            = '{FILL_COLOR_RESET, GLOBAL_ALPHA_RESET, FB_WIDTH_RESET,
                                FB_HEIGHT_RESET};
      current_setting       = '0;
      build_directed();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].setting != current_setting) begin
            drain_pipeline();
            current_setting = directed_rows[i].setting;
            load_settings(directed_settings[current_setting]);
         end
         send_job(directed_rows[i].job, directed_rows[i].typed, directed_rows[i].want);
      end

      per_phase = RANDOM_ITEMS / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         drain_pipeline();
         load_settings(random_settings());
         // last phase and the odd other one run back to back on both sides
         no_idle = (p == PHASES - 1) || ($urandom_range(0, 3) == 0);
         for (int n = 0; n < per_phase; n++) begin
            if ($urandom_range(0, 127) == 0)
               drain_pipeline();
            send_job(random_job(), 1'b0, '0);
         end
      end

      drain_pipeline();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_pixels.size() == 0)
         $display("argb_source_over_compositor regression: pass");
      else
         $display("argb_source_over_compositor regression: fail");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/asoc_pkg.sv
src/asoc_if.sv
src/asoc_pipe.sv
src/argb_source_over_compositor.sv
tb/sv/argb_source_over_compositor_tb.sv
